>>> hw/rtl/ppsu_pkg.sv
// Package: fixed-point types, constants and saturating helpers for the shrink unit.
`timescale 1ns / 1ps

package ppsu_pkg;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int DIV_NUM_W = DATA_W + FRAC_W;
   localparam int SQRT_RAD_W = DATA_W + FRAC_W;
   localparam int SQRT_ROOT_W = SQRT_RAD_W / 2;
   localparam int CSR_ADDR_W = 8;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef logic [DATA_W-1:0] mag_type;

   typedef struct packed {
      fix_type value;
      logic    sat;
   } fres_type;

   localparam logic [1:0] POT_QUAD  = 2'd0;
   localparam logic [1:0] POT_HUBER = 2'd1;
   localparam logic [1:0] POT_FAIR  = 2'd2;
   localparam logic [1:0] POT_ABS   = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_POTENTIAL = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_DELTA     = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE     = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] REG_BETA      = CSR_ADDR_W'(3);

   localparam fix_type FIX_ONE  = fix_type'(64'sd1 << FRAC_W);
   localparam fix_type FIX_FOUR = fix_type'(64'sd4 << FRAC_W);
   localparam logic [DATA_W-2:0] UNIT_RESET = (DATA_W-1)'(64'd1 << FRAC_W);

   function automatic fres_type f_clamp(input logic signed [DATA_W:0] x);
      fres_type r;
      r.sat   = x[DATA_W] != x[DATA_W-1];
      r.value = x[DATA_W-1:0];
      if (r.sat) begin
         r.value = {x[DATA_W], {(DATA_W-1){~x[DATA_W]}}};
      end
      return r;
   endfunction

   function automatic fres_type f_add(input fix_type a, input fix_type b);
      logic signed [DATA_W:0] s;
      s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
      return f_clamp(s);
   endfunction

   function automatic fres_type f_sub(input fix_type a, input fix_type b);
      logic signed [DATA_W:0] s;
      s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
      return f_clamp(s);
   endfunction

   function automatic mag_type f_mag(input fix_type a);
      return a[DATA_W-1] ? mag_type'(-a) : mag_type'(a);
   endfunction

   function automatic fix_type f_unsigned(input logic [DATA_W-2:0] v);
      return fix_type'({1'b0, v});
   endfunction

   // clip a magnitude to the signed range and apply the sign
   function automatic fres_type f_from_mag(input logic neg, input logic [PROD_W-1:0] m);
      fres_type r;
      logic [PROD_W-1:0] limit;
      logic [PROD_W-1:0] mc;
      limit = neg ? (PROD_W'(1) << (DATA_W-1)) : ((PROD_W'(1) << (DATA_W-1)) - PROD_W'(1));
      r.sat = m > limit;
      mc    = r.sat ? limit : m;
      r.value = neg ? fix_type'(-mc[DATA_W-1:0]) : fix_type'(mc[DATA_W-1:0]);
      return r;
   endfunction

   function automatic fres_type f_mul(input fix_type a, input fix_type b);
      logic [PROD_W-1:0] p;
      p = PROD_W'(f_mag(a)) * PROD_W'(f_mag(b));
      return f_from_mag(a[DATA_W-1] ^ b[DATA_W-1], p >> FRAC_W);
   endfunction

endpackage

>>> hw/rtl/ppsu_if.sv
// Interfaces: request, response and register write channels of the shrink unit.
`timescale 1ns / 1ps

interface ppsu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] y_first;
   logic signed [31:0] y_second;
   logic [30:0]        winv_first;
   logic [30:0]        winv_second;
   logic [30:0]        kappa_first;
   logic [30:0]        kappa_second;

   modport source (output valid, y_first, y_second, winv_first, winv_second,
                   kappa_first, kappa_second, input ready);
   modport sink   (input valid, y_first, y_second, winv_first, winv_second,
                   kappa_first, kappa_second, output ready);
endinterface

interface ppsu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] alpha_value;
   logic               zero_weight;
   logic               saturated;

   modport source (output valid, alpha_value, zero_weight, saturated, input ready);
   modport sink   (input valid, alpha_value, zero_weight, saturated, output ready);
endinterface

interface ppsu_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  addr;
   logic [31:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

>>> hw/rtl/ppsu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side-band payload.
`timescale 1ns / 1ps

module ppsu_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [PAY_W-1:0] out_pay
);

   logic             valid_ff [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];
   logic [NUM_W-1:0] quo_ff   [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [PAY_W-1:0] pay_ff   [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             src_valid;
      logic [NUM_W-1:0] src_num;
      logic [NUM_W-1:0] src_quo;
      logic [DEN_W-1:0] src_rem;
      logic [DEN_W-1:0] src_den;
      logic [PAY_W-1:0] src_pay;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             take;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_num   = in_num;
         assign src_quo   = '0;
         assign src_rem   = '0;
         assign src_den   = in_den;
         assign src_pay   = in_pay;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_num   = num_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_pay   = pay_ff[k-1];
      end

      // bring down the next dividend bit and try the subtract
      assign trial = {src_rem, src_num[NUM_W-1]};
      assign diff  = trial - {1'b0, src_den};
      assign take  = trial >= {1'b0, src_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[k] <= {src_num[NUM_W-2:0], 1'b0};
            quo_ff[k] <= {src_quo[NUM_W-2:0], take};
            rem_ff[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[k] <= src_den;
            pay_ff[k] <= src_pay;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];

endmodule

>>> hw/rtl/ppsu_sqrt.sv
// Pipelined restoring square root, one root bit per stage, with side-band payload.
`timescale 1ns / 1ps

module ppsu_sqrt #(
   parameter int RAD_W = 48,
   parameter int PAY_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_rad,
   input  logic [PAY_W-1:0]   in_pay,
   output logic               out_valid,
   output logic [RAD_W/2-1:0] out_root,
   output logic [PAY_W-1:0]   out_pay
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic              valid_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [PAY_W-1:0]  pay_ff   [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              src_valid;
      logic [RAD_W-1:0]  src_rad;
      logic [ROOT_W-1:0] src_root;
      logic [REM_W-1:0]  src_rem;
      logic [PAY_W-1:0]  src_pay;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  test;
      logic              take;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rad   = in_rad;
         assign src_root  = '0;
         assign src_rem   = '0;
         assign src_pay   = in_pay;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_pay   = pay_ff[k-1];
      end

      // bring down two radicand bits, test against 4*root+1
      assign trial = {src_rem[ROOT_W-1:0], src_rad[RAD_W-1 -: 2]};
      assign test  = {src_root, 2'b01};
      assign take  = trial >= test;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[k]  <= {src_rad[RAD_W-3:0], 2'b00};
            root_ff[k] <= {src_root[ROOT_W-2:0], take};
            rem_ff[k]  <= take ? trial - test : trial;
            pay_ff[k]  <= src_pay;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_pay   = pay_ff[ROOT_W-1];

endmodule

>>> hw/rtl/pairwise_potential_shrink_unit.sv
// Top level: pairwise potential shrink unit, one pixel pair per cycle unless stalled.
`timescale 1ns / 1ps

// Usage
//   req_chan : one pixel pair per item (image values, inverse weights, kappa factors).
//   rsp_chan : one result per item: alpha_value, zero_weight, saturated, in order.
//   csr_chan : register writes (0 potential, 1 shape_delta, 2 prox_scale,
//              3 offset_beta); always ready, other addresses are dropped.
//              Write only while no item is in flight.
// Throughput: one item per cycle whenever the receiver takes results.
// Pipeline: 130 register stages, in order: seven arithmetic stages,
//   a 48-stage divider for the quadratic/Huber shrink, a 24-stage square
//   root for fair-l1, two more stages and a 48-stage divider by the
//   weight sum, then the output register.
// All potentials run through the same stages.
// Reset clears every valid bit and loads the registers (potential 0, the
//   others 1.0); no result is offered until an item has crossed the pipe.
// When the receiver stalls with a result waiting, the whole pipe holds and
//   req_chan.ready drops in the same cycle; nothing is lost or repeated.

module pairwise_potential_shrink_unit (
   input logic         clock,
   input logic         reset,
   ppsu_req_if.sink    req_chan,
   ppsu_rsp_if.source  rsp_chan,
   ppsu_csr_if.sink    csr_chan
);

   import ppsu_pkg::*;

   typedef struct packed {
      fix_type z;
      fix_type cwc;
      fix_type s_direct;
      fix_type ama;
      fix_type sum;
      logic    neg;
      logic    hc;
      logic    sat;
   } diva_pay_type;

   typedef struct packed {
      fix_type z;
      fix_type cwc;
      fix_type s_direct;
      fix_type s_div;
      fix_type ama;
      logic    neg;
      logic    hc;
      logic    sat;
   } sqrt_pay_type;

   typedef struct packed {
      logic neg;
      logic cwc_zero;
      logic sat;
   } divb_pay_type;

   localparam int DIVA_PAY_W = $bits(diva_pay_type);
   localparam int SQRT_PAY_W = $bits(sqrt_pay_type);
   localparam int DIVB_PAY_W = $bits(divb_pay_type);

   // configuration registers
   logic [1:0]        pot_ff;
   logic [DATA_W-2:0] delta_ff;
   logic [DATA_W-2:0] scale_ff;
   logic [DATA_W-2:0] beta_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pot_ff   <= POT_QUAD;
         delta_ff <= UNIT_RESET;
         scale_ff <= UNIT_RESET;
         beta_ff  <= UNIT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            REG_POTENTIAL: pot_ff   <= csr_chan.data[1:0];
            REG_DELTA:     delta_ff <= csr_chan.data[DATA_W-2:0];
            REG_SCALE:     scale_ff <= csr_chan.data[DATA_W-2:0];
            REG_BETA:      beta_ff  <= csr_chan.data[DATA_W-2:0];
            default: ;
         endcase
      end
   end

   fix_type delta;
   logic    is_quad, is_huber, is_fair, is_abs;
   assign delta    = f_unsigned(delta_ff);
   assign is_quad  = pot_ff == POT_QUAD;
   assign is_huber = pot_ff == POT_HUBER;
   assign is_fair  = pot_ff == POT_FAIR;
   assign is_abs   = pot_ff == POT_ABS;

   logic out_v_ff;
   logic adv;
   // hold everything while a result waits
   assign adv = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: difference, weight sum, kappa product, scale*beta
   logic    v1_ff, sat1_ff, sat1_in;
   fix_type z1_ff, cwc1_ff, kap1_ff, p1_ff;
   fres_type r_z, r_cwc, r_kap, r_p1;

   always_comb begin
      r_z   = f_sub(req_chan.y_first, req_chan.y_second);
      r_cwc = f_add(f_unsigned(req_chan.winv_first), f_unsigned(req_chan.winv_second));
      r_kap = f_mul(f_unsigned(req_chan.kappa_first), f_unsigned(req_chan.kappa_second));
      r_p1  = f_mul(f_unsigned(scale_ff), f_unsigned(beta_ff));
      sat1_in = r_z.sat | r_cwc.sat | r_kap.sat | r_p1.sat;
   end

   // stage 2: times kappa, magnitude of z
   logic    v2_ff, sat2_ff, neg2_ff;
   fix_type z2_ff, cwc2_ff, p2_ff, az2_ff;
   fres_type r_p2, r_az;

   always_comb begin
      r_p2 = f_mul(p1_ff, kap1_ff);
      r_az = z1_ff[DATA_W-1] ? f_sub('0, z1_ff) : fres_type'{value: z1_ff, sat: 1'b0};
   end

   // stage 3: times weight sum gives reg
   logic    v3_ff, sat3_ff, neg3_ff;
   fix_type z3_ff, cwc3_ff, reg3_ff, az3_ff;
   fres_type r_reg;

   assign r_reg = f_mul(p2_ff, cwc2_ff);

   // stage 4: 1+reg, delta+reg, delta*reg, 4*delta
   logic    v4_ff, sat4_ff, neg4_ff, mdsat4_ff, sat4_in;
   fix_type z4_ff, cwc4_ff, az4_ff, onereg4_ff, a4_ff, md4_ff, m4_4_ff;
   fres_type r_onereg, r_a, r_md, r_m4;

   always_comb begin
      r_onereg = f_add(FIX_ONE, reg3_ff);
      r_a      = f_add(delta, reg3_ff);
      r_md     = f_mul(delta, reg3_ff);
      r_m4     = f_mul(FIX_FOUR, delta);
      sat4_in  = sat3_ff
               | ((pot_ff inside {POT_QUAD, POT_HUBER}) & r_onereg.sat)
               | (is_fair & (r_a.sat | r_m4.sat))
               | (is_abs & r_md.sat);
   end

   // stage 5: Huber threshold, fair-l1 terms, |z| - delta*reg
   logic    v5_ff, sat5_ff, neg5_ff, mdsat5_ff, damsat5_ff, sat5_in;
   fix_type z5_ff, cwc5_ff, az5_ff, onereg5_ff, d5_ff, th5_ff, m5_ff, dam5_ff, ama5_ff;
   fres_type r_d, r_th, r_m, r_dam, r_ama;

   always_comb begin
      r_d   = f_sub(a4_ff, az4_ff);
      r_th  = f_mul(delta, onereg4_ff);
      r_m   = f_mul(m4_4_ff, az4_ff);
      r_dam = f_sub(az4_ff, md4_ff);
      r_ama = f_sub(az4_ff, a4_ff);
      sat5_in = sat4_ff
              | (is_huber & r_th.sat)
              | (is_fair & (r_d.sat | r_m.sat | r_ama.sat))
              | (is_abs & r_dam.sat);
   end

   // stage 6: d squared, Huber branch, direct shrink values
   logic    v6_ff, sat6_ff, neg6_ff, hc6_ff, sat6_in, hc_in;
   fix_type z6_ff, cwc6_ff, onereg6_ff, dd6_ff, m6_ff, ama6_ff, sdir6_ff, sdir_in;
   fres_type r_dd, r_ndam, r_nabs;
   fix_type  t_abs;

   always_comb begin
      r_dd   = f_mul(d5_ff, d5_ff);
      hc_in  = th5_ff < az5_ff;
      r_ndam = f_sub('0, dam5_ff);
      t_abs  = dam5_ff[DATA_W-1] ? '0 : dam5_ff;
      r_nabs = f_sub('0, t_abs);
      if (is_abs) begin
         sdir_in = neg5_ff ? r_nabs.value : t_abs;
      end else begin
         sdir_in = neg5_ff ? r_ndam.value : dam5_ff;
      end
      sat6_in = sat5_ff
              | (is_fair & r_dd.sat)
              | (is_huber & hc_in & (mdsat5_ff | damsat5_ff | (neg5_ff & r_ndam.sat)));
   end

   // stage 7: fair-l1 radicand
   logic    v7_ff, sat7_ff, neg7_ff, hc7_ff;
   fix_type z7_ff, cwc7_ff, onereg7_ff, ama7_ff, sdir7_ff, sum7_ff;
   fres_type r_sum;

   assign r_sum = f_add(dd6_ff, m6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z1_ff   <= r_z.value;
         cwc1_ff <= r_cwc.value;
         kap1_ff <= r_kap.value;
         p1_ff   <= r_p1.value;
         sat1_ff <= sat1_in;

         z2_ff   <= z1_ff;
         cwc2_ff <= cwc1_ff;
         p2_ff   <= r_p2.value;
         az2_ff  <= r_az.value;
         neg2_ff <= z1_ff[DATA_W-1];
         sat2_ff <= sat1_ff | r_p2.sat | r_az.sat;

         z3_ff   <= z2_ff;
         cwc3_ff <= cwc2_ff;
         reg3_ff <= r_reg.value;
         az3_ff  <= az2_ff;
         neg3_ff <= neg2_ff;
         sat3_ff <= sat2_ff | r_reg.sat;

         z4_ff      <= z3_ff;
         cwc4_ff    <= cwc3_ff;
         az4_ff     <= az3_ff;
         neg4_ff    <= neg3_ff;
         onereg4_ff <= r_onereg.value;
         a4_ff      <= r_a.value;
         md4_ff     <= r_md.value;
         m4_4_ff    <= r_m4.value;
         mdsat4_ff  <= r_md.sat;
         sat4_ff    <= sat4_in;

         z5_ff      <= z4_ff;
         cwc5_ff    <= cwc4_ff;
         az5_ff     <= az4_ff;
         neg5_ff    <= neg4_ff;
         onereg5_ff <= onereg4_ff;
         d5_ff      <= r_d.value;
         th5_ff     <= r_th.value;
         m5_ff      <= r_m.value;
         dam5_ff    <= r_dam.value;
         ama5_ff    <= r_ama.value;
         mdsat5_ff  <= mdsat4_ff;
         damsat5_ff <= r_dam.sat;
         sat5_ff    <= sat5_in;

         z6_ff      <= z5_ff;
         cwc6_ff    <= cwc5_ff;
         onereg6_ff <= onereg5_ff;
         neg6_ff    <= neg5_ff;
         dd6_ff     <= r_dd.value;
         m6_ff      <= m5_ff;
         ama6_ff    <= ama5_ff;
         hc6_ff     <= hc_in;
         sdir6_ff   <= sdir_in;
         sat6_ff    <= sat6_in;

         z7_ff      <= z6_ff;
         cwc7_ff    <= cwc6_ff;
         onereg7_ff <= onereg6_ff;
         neg7_ff    <= neg6_ff;
         hc7_ff     <= hc6_ff;
         ama7_ff    <= ama6_ff;
         sdir7_ff   <= sdir6_ff;
         sum7_ff    <= r_sum.value;
         sat7_ff    <= sat6_ff | (is_fair & r_sum.sat);
      end
   end

   // divider A: |z| / (1+reg)
   diva_pay_type diva_in_pay, diva_out_pay;
   logic                 diva_out_valid;
   logic [DIV_NUM_W-1:0] diva_out_quo;

   always_comb begin
      diva_in_pay.z        = z7_ff;
      diva_in_pay.cwc      = cwc7_ff;
      diva_in_pay.s_direct = sdir7_ff;
      diva_in_pay.ama      = ama7_ff;
      diva_in_pay.sum      = sum7_ff;
      diva_in_pay.neg      = neg7_ff;
      diva_in_pay.hc       = hc7_ff;
      diva_in_pay.sat      = sat7_ff;
   end

   ppsu_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DATA_W),
      .PAY_W (DIVA_PAY_W)
   ) u_div_shrink (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v7_ff),
      .in_num    ({f_mag(z7_ff), {FRAC_W{1'b0}}}),
      .in_den    (f_mag(onereg7_ff)),
      .in_pay    (DIVA_PAY_W'(diva_in_pay)),
      .out_valid (diva_out_valid),
      .out_quo   (diva_out_quo),
      .out_pay   (diva_out_pay)
   );

   // square root for fair-l1
   sqrt_pay_type sqrt_in_pay, sqrt_out_pay;
   fres_type     r_sdiv;
   logic [SQRT_RAD_W-1:0]  sqrt_rad;
   logic                   sqrt_out_valid;
   logic [SQRT_ROOT_W-1:0] sqrt_out_root;

   always_comb begin
      r_sdiv = f_from_mag(diva_out_pay.neg, PROD_W'(diva_out_quo));
      sqrt_in_pay.z        = diva_out_pay.z;
      sqrt_in_pay.cwc      = diva_out_pay.cwc;
      sqrt_in_pay.s_direct = diva_out_pay.s_direct;
      sqrt_in_pay.s_div    = r_sdiv.value;
      sqrt_in_pay.ama      = diva_out_pay.ama;
      sqrt_in_pay.neg      = diva_out_pay.neg;
      sqrt_in_pay.hc       = diva_out_pay.hc;
      // the quotient only counts where it becomes the shrunk value
      sqrt_in_pay.sat      = diva_out_pay.sat
                           | (r_sdiv.sat & (is_quad | (is_huber & !diva_out_pay.hc)));
      sqrt_rad = diva_out_pay.sum[DATA_W-1] ? '0 : {mag_type'(diva_out_pay.sum), {FRAC_W{1'b0}}};
   end

   ppsu_sqrt #(
      .RAD_W (SQRT_RAD_W),
      .PAY_W (SQRT_PAY_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (diva_out_valid),
      .in_rad    (sqrt_rad),
      .in_pay    (SQRT_PAY_W'(sqrt_in_pay)),
      .out_valid (sqrt_out_valid),
      .out_root  (sqrt_out_root),
      .out_pay   (sqrt_out_pay)
   );

   // stage 9: finish fair-l1 and pick the shrunk value
   logic    v9_ff, sat9_ff, sat9_in;
   fix_type z9_ff, cwc9_ff, s9_ff, s_in, t_half, s_fair;
   fres_type r_t;

   always_comb begin
      r_t    = f_add(sqrt_out_pay.ama, fix_type'({{(DATA_W-SQRT_ROOT_W){1'b0}}, sqrt_out_root}));
      // halve toward zero
      t_half = (r_t.value + fix_type'({{(DATA_W-1){1'b0}}, r_t.value[DATA_W-1]})) >>> 1;
      s_fair = sqrt_out_pay.neg ? -t_half : t_half;
      case (pot_ff)
         POT_QUAD:  s_in = sqrt_out_pay.s_div;
         POT_HUBER: s_in = sqrt_out_pay.hc ? sqrt_out_pay.s_direct : sqrt_out_pay.s_div;
         POT_FAIR:  s_in = s_fair;
         POT_ABS:   s_in = sqrt_out_pay.s_direct;
         default:   s_in = sqrt_out_pay.s_div;
      endcase
      sat9_in = sqrt_out_pay.sat | (is_fair & r_t.sat);
   end

   // stage 10: shrunk minus z
   logic    v10_ff, sat10_ff;
   fix_type e10_ff, cwc10_ff;
   fres_type r_e;

   assign r_e = f_sub(s9_ff, z9_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (adv) begin
         v9_ff  <= sqrt_out_valid;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z9_ff    <= sqrt_out_pay.z;
         cwc9_ff  <= sqrt_out_pay.cwc;
         s9_ff    <= s_in;
         sat9_ff  <= sat9_in;
         e10_ff   <= r_e.value;
         cwc10_ff <= cwc9_ff;
         sat10_ff <= sat9_ff | r_e.sat;
      end
   end

   // divider B: correction / weight sum
   divb_pay_type divb_in_pay, divb_out_pay;
   logic                 divb_out_valid;
   logic [DIV_NUM_W-1:0] divb_out_quo;

   always_comb begin
      divb_in_pay.neg      = e10_ff[DATA_W-1];
      divb_in_pay.cwc_zero = cwc10_ff == '0;
      divb_in_pay.sat      = sat10_ff;
   end

   ppsu_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DATA_W),
      .PAY_W (DIVB_PAY_W)
   ) u_div_weight (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v10_ff),
      .in_num    ({f_mag(e10_ff), {FRAC_W{1'b0}}}),
      .in_den    (f_mag(cwc10_ff)),
      .in_pay    (DIVB_PAY_W'(divb_in_pay)),
      .out_valid (divb_out_valid),
      .out_quo   (divb_out_quo),
      .out_pay   (divb_out_pay)
   );

   // output register
   fix_type  alpha_ff;
   logic     zw_ff, sat_ff;
   fres_type r_alpha;

   assign r_alpha = f_from_mag(divb_out_pay.neg, PROD_W'(divb_out_quo));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= divb_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // zero weight sum forces a clean zero result
         if (divb_out_pay.cwc_zero) begin
            alpha_ff <= '0;
            zw_ff    <= 1'b1;
            sat_ff   <= 1'b0;
         end else begin
            alpha_ff <= r_alpha.value;
            zw_ff    <= 1'b0;
            sat_ff   <= divb_out_pay.sat | r_alpha.sat;
         end
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.alpha_value = alpha_ff;
   assign rsp_chan.zero_weight = zw_ff;
   assign rsp_chan.saturated   = sat_ff;

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while a result is stalled");

   a_zero_weight_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_weight |->
         rsp_chan.alpha_value == 0 && !rsp_chan.saturated)
      else $error("zero weight result not clean");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result offered straight after reset");

endmodule
